// File: hw/rtl/sae_pkg.sv
`default_nettype none
package sae_pkg;

	localparam int SAE_STACK_DEPTH = 64;

	localparam int WORD_W  = 32;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int DEPTH_W = 7;

	// Stream widths, rounded up to whole bytes.
	localparam int IN_W  = ((CMD_W + WORD_W + 7) / 8) * 8;
	localparam int OUT_W = ((STAT_W + WORD_W + DEPTH_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 3'd0,
		CMD_SWAP = 3'd1,
		CMD_ADD  = 3'd2,
		CMD_SUB  = 3'd3,
		CMD_DIV  = 3'd4,
		CMD_NOP  = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_SHORT   = 2'd1,
		STAT_DIVZERO = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_CALC,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/stack_alu_engine_unit.sv
`default_nettype none
// Stack machine ALU over signed 32-bit words. Each input transfer carries an opcode
// (push, swap, add, sub, div, nop) and a push value; each one gives exactly one output
// transfer with a status, the new top of stack (zero when empty) and the new depth.
// The top entry is held in a register and the entries below it in a RAM of STACK_DEPTH
// words with one write port and one registered read port. Items are handled one at a
// time, and ready returns only once the result sits in the output register: push, nop
// and items rejected for a short stack pass through ST_DECODE and ST_RESP, swap and division by
// zero through ST_READ too, and add, sub and div also wait in ST_CALC for the ALU, whose
// divider produces one quotient bit per cycle. A result stalled at the output keeps the item
// in ST_RESP until the output register is free. Errors leave the stack unchanged.
module stack_alu_engine_unit #(
	parameter int STACK_DEPTH = sae_pkg::SAE_STACK_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// [2:0] cmd, [34:3] push_value, [39:35] zero
	input  wire logic [sae_pkg::IN_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// [1:0] status, [33:2] top_value, [40:34] depth_now, [47:41] zero
	output logic      [sae_pkg::OUT_W-1:0] m_tdata
);

	import sae_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [WORD_W-1:0] val_q;
	logic [CW-1:0]     count_q;
	logic [WORD_W-1:0] top_q;
	status_t           status_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [CW-1:0]     cnt_m1, cnt_m2;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;
	alu_req_t          alu_req;
	logic              alu_done;
	logic [WORD_W-1:0] alu_result;
	logic              top_ld, cnt_inc, cnt_dec, stat_ld, out_ld, slot_free;
	logic [WORD_W-1:0] top_d;
	status_t           stat_d;
	logic [WORD_W-1:0] top_out;

	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	assign slot_free = !out_valid_q || m_tready;

	sae_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (rdata)
	);

	sae_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (rdata),
		.b      (top_q),
		.done   (alu_done),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		we            = 1'b0;
		waddr         = cnt_m1[AW-1:0];
		wdata         = top_q;
		alu_req.start = 1'b0;
		alu_req.op    = ALU_ADD;
		top_ld        = 1'b0;
		top_d         = top_q;
		cnt_inc       = 1'b0;
		cnt_dec       = 1'b0;
		stat_ld       = 1'b0;
		stat_d        = STAT_OK;
		out_ld        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				stat_ld = 1'b1;
				state_d = ST_RESP;
				case (cmd_q)
					CMD_PUSH: begin
						if (count_q == CW'(STACK_DEPTH)) begin
							stat_d = STAT_FULL;
						end else begin
							// The old top moves down into the RAM.
							we      = (count_q != '0);
							top_ld  = 1'b1;
							top_d   = val_q;
							cnt_inc = 1'b1;
						end
					end
					CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV: begin
						if (count_q < CW'(2)) begin
							stat_d = STAT_SHORT;
						end else begin
							state_d = ST_READ;
						end
					end
					default: begin
					end
				endcase
			end
			ST_READ: begin
				stat_ld = 1'b1;
				state_d = ST_RESP;
				if (cmd_q == CMD_SWAP) begin
					we     = 1'b1;
					waddr  = cnt_m2[AW-1:0];
					top_ld = 1'b1;
					top_d  = rdata;
				end else if (cmd_q == CMD_DIV && top_q == '0) begin
					stat_d = STAT_DIVZERO;
				end else begin
					alu_req.start = 1'b1;
					case (cmd_q)
						CMD_ADD: alu_req.op = ALU_ADD;
						CMD_SUB: alu_req.op = ALU_SUB;
						default: alu_req.op = ALU_DIV;
					endcase
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (alu_done) begin
					top_ld  = 1'b1;
					top_d   = alu_result;
					cnt_dec = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= cnt_m1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign top_out = (count_q != '0) ? top_q : '0;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_t'(s_tdata[CMD_W-1:0]);
			val_q <= s_tdata[CMD_W +: WORD_W];
		end
		if (top_ld) begin
			top_q <= top_d;
		end
		if (stat_ld) begin
			status_q <= stat_d;
		end
		if (out_ld) begin
			out_data_q <= OUT_W'({DEPTH_W'(count_q), top_out, status_q});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

// File: hw/rtl/sae_ram.sv
`default_nettype none
module sae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/sae_alu.sv
`default_nettype none
module sae_alu (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sae_pkg::alu_req_t         req,
	input  wire logic [sae_pkg::WORD_W-1:0] a,
	input  wire logic [sae_pkg::WORD_W-1:0] b,
	output logic                           done,
	output logic      [sae_pkg::WORD_W-1:0] result
);

	import sae_pkg::*;

	localparam int CNT_W = $clog2(WORD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] mb_q;
	logic [WORD_W-1:0] result_q;

	logic [WORD_W:0]   rem_sh;
	logic [WORD_W:0]   diff;
	logic              ge;

	// One restoring step: shift in the next dividend bit and try the subtract.
	assign rem_sh = {rem_q, quo_q[WORD_W-1]};
	assign diff   = rem_sh - {1'b0, mb_q};
	assign ge     = !diff[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				case (req.op)
					ALU_ADD, ALU_SUB: begin
						done_q <= 1'b1;
					end
					default: begin
						done_q <= 1'b0;
						busy_q <= 1'b1;
						cnt_q  <= CNT_W'(WORD_W);
					end
				endcase
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					done_q <= 1'b0;
					cnt_q  <= cnt_q - CNT_W'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				ALU_ADD: begin
					result_q <= a + b;
				end
				ALU_SUB: begin
					result_q <= a - b;
				end
				default: begin
					quo_q <= a[WORD_W-1] ? (WORD_W'(0) - a) : a;
					mb_q  <= b[WORD_W-1] ? (WORD_W'(0) - b) : b;
					rem_q <= '0;
					neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
				end
			endcase
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				quo_q <= {quo_q[WORD_W-2:0], ge};
				rem_q <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			end else begin
				// Signs differ: the quotient is negated, which truncates toward zero.
				result_q <= neg_q ? (WORD_W'(0) - quo_q) : quo_q;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// File: hw/rtl/sae_checker.sv
`default_nettype none
module sae_checker #(
	parameter int STACK_DEPTH = sae_pkg::SAE_STACK_DEPTH
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [sae_pkg::OUT_W-1:0] m_tdata
);

	import sae_pkg::*;

	// A stalled result must hold still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Items are taken one at a time, so ready drops after each input transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// A full stack reports its full depth.
	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == STAT_FULL |->
			m_tdata[40:34] == DEPTH_W'(STACK_DEPTH))
		else $error("stack full reported at the wrong depth");

	// A division by zero leaves the zero divisor on top.
	a_divzero_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == STAT_DIVZERO |-> m_tdata[33:2] == '0)
		else $error("division by zero reported with a non-zero top");

endmodule

bind stack_alu_engine_unit sae_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sae_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
